// ===== rtl/lfu_pkg.sv =====
// Shared types for the LFU cache table: controller states and control structs
`timescale 1ns / 1ps
`default_nettype none
package lfu_pkg;
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE,
    ST_OUT
  } lfu_state_t;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;
  localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;
  localparam int CFG_CAPACITY = 0;

  typedef struct packed {
    logic load;
    logic search;
    logic update;
  } lfu_cmd_t;
endpackage
`default_nettype wire

// ===== rtl/lfu_ctrl.sv =====
// Controller state machine for the LFU cache table
`timescale 1ns / 1ps
`default_nettype none
module lfu_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output lfu_pkg::lfu_cmd_t    cmd
);
  import lfu_pkg::*;

  lfu_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_SEARCH;
      ST_SEARCH: state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_OUT;
      ST_OUT: begin
        if (out_ready) begin
          state_next = in_valid ? ST_SEARCH : ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE:   begin in_ready = 1'b1; cmd.load = in_valid; end
      ST_SEARCH: cmd.search = 1'b1;
      ST_UPDATE: cmd.update = 1'b1;
      ST_OUT: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
        cmd.load  = out_ready & in_valid;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/lfu_dp.sv =====
// Datapath of the LFU cache table: entry registers, match, victim search, update
`timescale 1ns / 1ps
`default_nettype none
module lfu_dp #(
  parameter int TABLE_DEPTH = 16,
  parameter int COUNT_BITS  = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lfu_pkg::lfu_cmd_t  cmd,
  input  wire logic [4:0]         capacity,
  input  wire logic               opcode,
  input  wire logic signed [31:0] lookup_key,
  input  wire logic signed [31:0] write_value,
  output logic                    hit,
  output logic signed [31:0]      read_value,
  output logic                    evicted,
  output logic signed [31:0]      evicted_key
);
  import lfu_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NW = $clog2(TABLE_DEPTH + 1);
  localparam int CW = (TABLE_DEPTH > 31) ? NW : 5;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic [TABLE_DEPTH-1:0] valid;
  logic [31:0]            keys   [TABLE_DEPTH];
  logic [31:0]            vals   [TABLE_DEPTH];
  logic [COUNT_BITS-1:0]  counts [TABLE_DEPTH];
  logic [IW-1:0]          ranks  [TABLE_DEPTH];

  logic        op;
  logic [31:0] key, wval;

  // registered search results
  logic          s_found, s_has_free, s_has_vic, s_full;
  logic [IW-1:0] s_fidx, s_free, s_vic;
  logic [NW-1:0] s_nvalid;

  logic          c_found, c_has_free, c_has_vic;
  logic [IW-1:0] c_fidx, c_free, c_vic;
  logic [NW-1:0] c_nvalid;
  logic [CW-1:0] cap_eff;
  logic [TABLE_DEPTH-1:0] c_best;

  always_comb begin
    c_found = 1'b0; c_fidx = '0;
    c_has_free = 1'b0; c_free = '0;
    c_has_vic = 1'b0; c_vic = '0;
    c_nvalid = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (valid[i] && keys[i] == key) begin
        c_found = 1'b1; c_fidx = IW'(i);
      end
      if (valid[i]) c_nvalid = c_nvalid + 1'b1;
    end
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        c_has_free = 1'b1; c_free = IW'(i);
      end
    end
    // compare every valid pair at once; the entry no other entry beats is the victim
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      c_best[i] = valid[i];
      for (int j = 0; j < TABLE_DEPTH; j++) begin
        if (j != i && valid[j] && (counts[j] < counts[i] ||
            (counts[j] == counts[i] && ranks[j] < ranks[i])))
          c_best[i] = 1'b0;
      end
    end
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (c_best[i]) begin
        c_has_vic = 1'b1; c_vic = IW'(i);
      end
    end
    if (CW'(capacity) > CW'(TABLE_DEPTH)) cap_eff = CW'(TABLE_DEPTH);
    else cap_eff = CW'(capacity);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= opcode; key <= lookup_key; wval <= write_value;
    end
    if (cmd.search) begin
      s_found <= c_found; s_fidx <= c_fidx;
      s_has_free <= c_has_free; s_free <= c_free;
      s_has_vic <= c_has_vic; s_vic <= c_vic;
      s_nvalid <= c_nvalid;
      s_full <= (CW'(c_nvalid) >= cap_eff) && (cap_eff != '0);
    end
  end

  logic          do_touch, do_ins, do_ev;
  logic [IW-1:0] slot;
  logic [IW-1:0] ref_rank;
  logic [IW-1:0] new_rank;

  always_comb begin
    do_touch = s_found && (op == OP_GET || cap_eff != '0);
    do_ev    = op == OP_PUT && !s_found && cap_eff != '0 && s_full && s_has_vic;
    do_ins   = op == OP_PUT && !s_found && cap_eff != '0 && (do_ev || s_has_free);
    slot     = s_found ? s_fidx : (do_ev ? s_vic : s_free);
    ref_rank = ranks[slot];
    new_rank = IW'(s_nvalid - 1'b1);
    if (do_ins && !do_ev) new_rank = IW'(s_nvalid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.update && do_ins) begin
      valid[slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if ((do_touch || do_ev) && valid[i] && IW'(i) != slot && ranks[i] > ref_rank)
          ranks[i] <= ranks[i] - 1'b1;
      end
      if (do_touch || do_ins) ranks[slot] <= new_rank;
      if (do_touch) begin
        if (counts[slot] != CMAX) counts[slot] <= counts[slot] + 1'b1;
        if (op == OP_PUT) vals[slot] <= wval;
      end
      if (do_ins) begin
        keys[slot] <= key; vals[slot] <= wval;
        counts[slot] <= COUNT_BITS'(1);
      end
      hit         <= do_touch;
      read_value  <= (op == OP_GET) ? (s_found ? vals[s_fidx] : MISS_VALUE) : '0;
      evicted     <= do_ev;
      evicted_key <= do_ev ? keys[s_vic] : '0;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/lfu_cache_table.sv =====
// Top level of the LFU cache table with APB configuration port
// Usage:
//   Input channel in_valid/in_ready carries opcode (0 get, 1 put),
//   lookup_key and write_value. Output channel out_valid/out_ready carries
//   hit, read_value, evicted and evicted_key; one result per transaction.
//   Each transaction passes through a search state, which matches keys and
//   searches the victim across all entries in parallel, and an update
//   state, which updates counts and recency ranks; then the result is held
//   until taken. A new transaction is accepted in the cycle the result
//   leaves, so transactions do not overlap.
//   A stalled receiver holds the result and blocks new input.
//   Reset clears all entry valid bits and sets capacity to 16; entry
//   contents need no clearing pass.
//   The APB port holds capacity at address 0; write only while idle.
`timescale 1ns / 1ps
`default_nettype none
module lfu_cache_table #(
  parameter int TABLE_DEPTH = 16,
  parameter int COUNT_BITS  = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               opcode,
  input  wire logic signed [31:0] lookup_key,
  input  wire logic signed [31:0] write_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    hit,
  output logic signed [31:0]      read_value,
  output logic                    evicted,
  output logic signed [31:0]      evicted_key,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [1:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import lfu_pkg::*;

  logic [4:0] capacity;
  lfu_cmd_t   cmd;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= 5'd16;
    end else if (psel && penable && pwrite && paddr == 2'(CFG_CAPACITY * 4)) begin
      capacity <= pwdata[4:0];
    end
  end
  assign prdata = (paddr == 2'(CFG_CAPACITY * 4)) ? {27'd0, capacity} : '0;

  lfu_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .cmd
  );

  lfu_dp #(.TABLE_DEPTH(TABLE_DEPTH), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk, .rst, .cmd, .capacity, .opcode, .lookup_key, .write_value,
    .hit, .read_value, .evicted, .evicted_key
  );

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.search, cmd.update})) else $error("command overlap");
  a_ev_put: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted |-> !hit) else $error("eviction on hit");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_value))
    else $error("result dropped");
  a_evk: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evicted |-> evicted_key == '0) else $error("stray evicted key");
endmodule
`default_nettype wire
